@@ design/ppc_pkg.sv @@
package ppc_pkg;

   localparam int COORD_W           = 16;
   localparam int SUM_W             = 24;
   localparam int COUNT_W           = 8;
   localparam int SQ_W              = 2 * (COORD_W + 1);
   localparam int ROOT_W            = COORD_W + 1;
   localparam int REM_W             = ROOT_W + 3;
   localparam int ITER_W            = $clog2(ROOT_W);
   localparam int MAX_SIDES_DEFAULT = 128;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]   perimeter;
      logic [COUNT_W-1:0] side_count;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic sel_first;
      logic square_x;
      logic square_y;
      logic root_step;
      logic accumulate;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_edge;
      logic last;
      logic root_done;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_ACC,
      ST_FINISH
   } state_type;

endpackage

@@ design/ppc_ctrl.sv @@
module ppc_ctrl
   import ppc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;
   logic      close_ff, close_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         close_ff <= close_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      close_in = close_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
               close_in = 1'b0;
            end
         end
         ST_DISPATCH: begin
            priority if (status.need_edge) begin
               state_in = ST_SQ_X;
            end else if (status.last) begin
               state_in = ST_SQ_X;
               close_in = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!close_ff && status.last) begin
               state_in = ST_SQ_X;
               close_in = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.sel_first  = close_ff;
      busy           = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_DISPATCH: ;
         ST_SQ_X:   cmd.square_x   = 1'b1;
         ST_SQ_Y:   cmd.square_y   = 1'b1;
         ST_ROOT:   cmd.root_step  = 1'b1;
         ST_ACC:    cmd.accumulate = 1'b1;
         ST_FINISH: cmd.finish     = 1'b1;
         default:   busy           = 1'b1;
      endcase
   end

endmodule

@@ design/ppc_datapath.sv @@
module ppc_datapath
   import ppc_pkg::*;
#(
   parameter int MAX_SIDES = MAX_SIDES_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_item,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_item
);

   logic signed [COORD_W-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic                      last_ff, need_edge_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      ovf_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [ITER_W-1:0]         iter_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_item_ff;

   logic signed [COORD_W-1:0] other_x, other_y;
   logic signed [COORD_W:0]   diff_x, diff_y, diff_sel;
   logic signed [SQ_W-1:0]    prod;
   logic [REM_W-1:0]          rem_shift, trial;
   logic [SUM_W:0]            sum_ext;
   logic [COUNT_W-1:0]        count_next;
   logic                      ovf_next;

   assign other_x   = cmd.sel_first ? first_x_ff : prev_x_ff;
   assign other_y   = cmd.sel_first ? first_y_ff : prev_y_ff;
   assign diff_x    = {cur_x_ff[COORD_W-1], cur_x_ff} - {other_x[COORD_W-1], other_x};
   assign diff_y    = {cur_y_ff[COORD_W-1], cur_y_ff} - {other_y[COORD_W-1], other_y};
   assign diff_sel  = cmd.square_y ? diff_y : diff_x;
   assign prod      = diff_sel * diff_sel;
   assign rem_shift = {rem_ff[REM_W-3:0], sq_ff[SQ_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign sum_ext   = {1'b0, sum_ff} + (SUM_W + 1)'(root_ff);

   always_comb begin
      count_next = count_ff;
      ovf_next   = ovf_ff;
      if (need_edge_ff) begin
         if (count_ff >= COUNT_W'(MAX_SIDES)) begin
            ovf_next = 1'b1;
         end else begin
            count_next = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.capture && count_ff == '0) begin
            first_x_ff <= req_item.x_coord;
            first_y_ff <= req_item.y_coord;
            count_ff   <= COUNT_W'(1);
         end
         if (cmd.accumulate) begin
            if (sum_ext[SUM_W]) begin
               sum_ff <= '1;
               ovf_ff <= 1'b1;
            end else begin
               sum_ff <= sum_ext[SUM_W-1:0];
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= last_ff;
            if (last_ff) begin
               first_x_ff <= '0;
               first_y_ff <= '0;
               prev_x_ff  <= '0;
               prev_y_ff  <= '0;
               sum_ff     <= '0;
               count_ff   <= '0;
               ovf_ff     <= 1'b0;
            end else begin
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
               count_ff  <= count_next;
               ovf_ff    <= ovf_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_x_ff     <= req_item.x_coord;
         cur_y_ff     <= req_item.y_coord;
         last_ff      <= req_item.last_point;
         need_edge_ff <= (count_ff != '0);
      end
      if (cmd.square_x) begin
         sq_ff <= unsigned'(prod);
      end
      if (cmd.square_y) begin
         sq_ff   <= sq_ff + unsigned'(prod);
         rem_ff  <= '0;
         root_ff <= '0;
         iter_ff <= ITER_W'(ROOT_W - 1);
      end
      if (cmd.root_step) begin
         sq_ff   <= {sq_ff[SQ_W-3:0], 2'b00};
         iter_ff <= iter_ff - 1'b1;
         if (rem_shift >= trial) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         rsp_item_ff.perimeter  <= sum_ff;
         rsp_item_ff.side_count <= count_next;
         rsp_item_ff.overflow   <= ovf_next;
      end
   end

   assign status.need_edge = need_edge_ff;
   assign status.last      = last_ff;
   assign status.root_done = (iter_ff == '0);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item         = rsp_item_ff;

endmodule

@@ design/polygon_perimeter_core.sv @@
// Each vertex passes through dispatch and finish; every edge that it closes adds the
// squaring of x and then y on the shared multiplier, 17 square-root iterations and
// one accumulate. The last vertex also closes the edge back to the first vertex;
// the result strobe comes in the first cycle in which busy is low.
// The receiver cannot stall. Synchronous active-high reset clears the controller,
// the first and previous vertices, the running sum, the vertex count and the overflow flag.
module polygon_perimeter_core
   import ppc_pkg::*;
#(
   parameter int MAX_SIDES = MAX_SIDES_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   ppc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ppc_datapath #(
      .MAX_SIDES (MAX_SIDES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // A result only appears once the controller has returned to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.side_count != '0 &&
                     rsp_item.side_count <= COUNT_W'(MAX_SIDES)))
      else $error("side count out of range");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted transfer did not raise busy");

endmodule

@@ dv/polygon_perimeter_checker.sv @@
`timescale 1ns / 1ps

module polygon_perimeter_checker
   import ppc_pkg::*;
#(
   parameter int MAX_SIDES = MAX_SIDES_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      error_count,
   output int      pending_results
);

   localparam longint unsigned SUM_CEILING = (longint'(1) << SUM_W) - 1;

   logic signed [COORD_W-1:0] first_x;
   logic signed [COORD_W-1:0] first_y;
   logic signed [COORD_W-1:0] prev_x;
   logic signed [COORD_W-1:0] prev_y;
   logic [SUM_W-1:0]          sum_so_far;
   logic [COUNT_W-1:0]        vertices_seen;
   logic                      saturated;
   rsp_type                   expected_perimeters[$];
   int                        mismatches = 0;

   initial begin
      error_count     = 0;
      pending_results = 0;
   end

   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
         trial = root | (longint'(1) << i);
         if (trial * trial <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic longint unsigned edge_length(
      input logic signed [COORD_W-1:0] ax,
      input logic signed [COORD_W-1:0] ay,
      input logic signed [COORD_W-1:0] bx,
      input logic signed [COORD_W-1:0] by
   );
      longint dx;
      longint dy;
      dx = longint'(bx) - longint'(ay - ay + ax);
      dy = longint'(by) - longint'(ay);
      return floor_root(longint'(dx * dx + dy * dy));
   endfunction

   task automatic add_length(input longint unsigned len);
      longint unsigned total;
      total = longint'(sum_so_far) + len;
      if (total > SUM_CEILING) begin
         sum_so_far = '1;
         saturated  = 1'b1;
      end else begin
         sum_so_far = total[SUM_W-1:0];
      end
   endtask

   task automatic clear_polygon();
      first_x       = '0;
      first_y       = '0;
      prev_x        = '0;
      prev_y        = '0;
      sum_so_far    = '0;
      vertices_seen = '0;
      saturated     = 1'b0;
   endtask

   task automatic take_vertex(input req_type v);
      rsp_type outcome;
      if (vertices_seen == '0) begin
         first_x       = v.x_coord;
         first_y       = v.y_coord;
         vertices_seen = COUNT_W'(1);
      end else begin
         add_length(edge_length(prev_x, prev_y, v.x_coord, v.y_coord));
         if (vertices_seen >= COUNT_W'(MAX_SIDES)) begin
            saturated = 1'b1;
         end else begin
            vertices_seen = vertices_seen + 1'b1;
         end
      end
      prev_x = v.x_coord;
      prev_y = v.y_coord;
      if (v.last_point) begin
         add_length(edge_length(v.x_coord, v.y_coord, first_x, first_y));
         outcome.perimeter  = sum_so_far;
         outcome.side_count = vertices_seen;
         outcome.overflow   = saturated;
         expected_perimeters.push_back(outcome);
         clear_polygon();
      end
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (expected_perimeters.size() == 0) begin
         $error("unexpected result: perimeter %0d, side_count %0d, overflow %0d",
                got.perimeter, got.side_count, got.overflow);
         mismatches++;
      end else begin
         want = expected_perimeters.pop_front();
         if (got.perimeter !== want.perimeter) begin
            $error("perimeter: expected %0d, actual %0d", want.perimeter, got.perimeter);
            mismatches++;
         end
         if (got.side_count !== want.side_count) begin
            $error("side_count: expected %0d, actual %0d", want.side_count, got.side_count);
            mismatches++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_polygon();
         expected_perimeters.delete();
      end else begin
         if (rsp_valid) begin
            compare_result(rsp_item);
         end
         if (start && !busy) begin
            take_vertex(req_item);
         end
      end
      pending_results <= expected_perimeters.size();
      error_count     <= mismatches;
   end

endmodule

@@ dv/polygon_perimeter_core_tb.sv @@
`timescale 1ns / 1ps

module polygon_perimeter_core_tb;
   import ppc_pkg::*;

   localparam int SIDE_LIMIT   = MAX_SIDES_DEFAULT;
   localparam int ITEM_TARGET  = 1900;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   typedef enum int {
      SHAPE_SCATTERED,
      SHAPE_EXTREME,
      SHAPE_CROWDED,
      SHAPE_SATURATING
   } shape_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      error_count;
   int      pending_results;
   int      idle_percent = 0;
   int      vertices_sent = 0;
   int      quiet_cycles = 0;

   always #1 clock = ~clock;

   polygon_perimeter_core #(
      .MAX_SIDES(SIDE_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   polygon_perimeter_checker #(
      .MAX_SIDES(SIDE_LIMIT)
   ) result_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .error_count    (error_count),
      .pending_results(pending_results)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_vertex(input int x, input int y, input logic last);
      req_type v;
      v.x_coord    = x[COORD_W-1:0];
      v.y_coord    = y[COORD_W-1:0];
      v.last_point = last;
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= v;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      vertices_sent++;
   endtask

   function automatic int pick_coord(input shape_type kind, input int index);
      int corners[4];
      corners = '{-32768, 32767, 0, -1};
      case (kind)
         SHAPE_EXTREME: begin
            return corners[$urandom_range(3)];
         end
         SHAPE_CROWDED: begin
            return $urandom_range(4095) - 2048;
         end
         SHAPE_SATURATING: begin
            return (index % 2 == 0) ? -32768 : 32767;
         end
         default: begin
            if ($urandom_range(1) == 0) begin
               return int'($urandom);
            end
            return $urandom_range(1023) - 512;
         end
      endcase
   endfunction

   task automatic send_polygon(input shape_type kind);
      int sides;
      case (kind)
         SHAPE_EXTREME:    sides = $urandom_range(3, 1);
         SHAPE_CROWDED:    sides = $urandom_range(SIDE_LIMIT + 3, SIDE_LIMIT - 2);
         SHAPE_SATURATING: sides = $urandom_range(200, 190);
         default:          sides = $urandom_range(10, 1);
      endcase
      for (int i = 0; i < sides; i++) begin
         send_vertex(pick_coord(kind, i), pick_coord(kind, i), i == sides - 1);
      end
   endtask

   initial begin
      int idle_profile[3];
      int phase_target;
      int roll;
      idle_profile = '{34, 69, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vertex(0, 0, 1'b1);
      send_vertex(-32768, 32767, 1'b1);
      send_vertex(-32768, -32768, 1'b0);
      send_vertex(32767, 32767, 1'b1);
      send_vertex(32767, -32768, 1'b0);
      send_vertex(-32768, 32767, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(768, 0, 1'b0);
      send_vertex(0, 1024, 1'b1);
      send_vertex(-256, -256, 1'b0);
      send_vertex(256, -256, 1'b0);
      send_vertex(256, 256, 1'b0);
      send_vertex(-256, 256, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(1, 1, 1'b1);
      send_vertex(-1, -1, 1'b0);
      send_vertex(-1, -1, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = idle_profile[phase];
         phase_target = vertices_sent + ITEM_TARGET / 3;
         while (vertices_sent < phase_target) begin
            roll = $urandom_range(99);
            if (roll < 2) begin
               send_polygon(SHAPE_SATURATING);
            end else if (roll < 5) begin
               send_polygon(SHAPE_CROWDED);
            end else if (roll < 11) begin
               send_polygon(SHAPE_EXTREME);
            end else begin
               send_polygon(SHAPE_SCATTERED);
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
